// File: rtl/palbl_pkg.sv
// ----------------------------------------------------------------------------
// palbl_pkg
// Shared types and constants of the per-address leaky bucket limiter.
// ----------------------------------------------------------------------------
package palbl_pkg;

   localparam int ADDR_W   = 32;
   localparam int TIME_W   = 32;
   localparam int BURST_W  = 10;
   localparam int PERIOD_W = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BURST_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_MS   = 1'd1;

   localparam logic [BURST_W-1:0]  BURST_RESET  = 10'd10;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP_RD,
      ST_LOOKUP_CHK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SLOT_RD,
      ST_DIV,
      ST_UPDATE,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;     // capture request, clear index
      logic rd_entry;     // read entry at index
      logic inc_index;
      logic clr_index;
      logic alloc_entry;  // write new bucket at index
      logic div_start;
      logic div_step;
      logic write_slot;   // write drained bucket
      logic emit;         // pulse result
      logic emit_full;    // result is a table-full limit
      logic emit_local;
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic is_local;
      logic hit;          // valid entry matches address
      logic expired;      // valid entry may be freed
      logic slot_free;    // entry invalid
      logic last_index;
      logic div_done;
   } stat_type;

endpackage

// File: rtl/per_address_leaky_bucket_limiter.sv
// ----------------------------------------------------------------------------
// per_address_leaky_bucket_limiter
// Per-address leaky bucket rate limiter over a table of NUM_ENTRIES buckets.
// ----------------------------------------------------------------------------
// One request at a time; busy is high from acceptance until the result.
// A local request is answered from ST_LOOKUP_RD without a table read.
// Otherwise the lookup sweep reads the entries one by one until a hit, a miss
// then runs an allocation sweep up to the first free or expired entry, and
// the drain division by period_ms produces one quotient bit per cycle. The
// worst case is set by the single-port table sweep. The result strobe
// rsp_valid lasts one cycle and cannot be stalled. Valid bits clear at
// reset; no clearing pass is needed.
module per_address_leaky_bucket_limiter #(
   parameter int NUM_ENTRIES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [palbl_pkg::ADDR_W-1:0]      req_peer_address,
   input  logic [palbl_pkg::TIME_W-1:0]      req_now_ms,
   input  logic                              req_is_local,
   output logic                              rsp_valid,
   output logic                              rsp_limited,
   output logic                              rsp_no_room,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [palbl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [palbl_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   palbl_pkg::ctrl_type ctrl;
   palbl_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   palbl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   palbl_dp #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_peer_address (req_peer_address),
      .req_now_ms       (req_now_ms),
      .req_is_local     (req_is_local),
      .csr_wr           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .ctrl             (ctrl),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_limited      (rsp_limited),
      .rsp_no_room      (rsp_no_room)
   );

endmodule

// File: rtl/palbl_ctrl.sv
// ----------------------------------------------------------------------------
// palbl_ctrl
// Sequencer: lookup sweep, allocation sweep, drain division, bucket update.
// ----------------------------------------------------------------------------
module palbl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  palbl_pkg::stat_type  stat,
   output palbl_pkg::ctrl_type  ctrl
);

   palbl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= palbl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      busy     = (state_ff != palbl_pkg::ST_IDLE);
      case (state_ff)
         palbl_pkg::ST_IDLE: begin
            if (start) begin
               ctrl.load_req = 1'b1;
               state_in = palbl_pkg::ST_LOOKUP_RD;
            end
         end
         palbl_pkg::ST_LOOKUP_RD: begin
            if (stat.is_local) begin
               ctrl.emit = 1'b1;
               ctrl.emit_local = 1'b1;
               state_in = palbl_pkg::ST_IDLE;
            end else begin
               ctrl.rd_entry = 1'b1;
               state_in = palbl_pkg::ST_LOOKUP_CHK;
            end
         end
         palbl_pkg::ST_LOOKUP_CHK: begin
            if (stat.hit) begin
               ctrl.rd_entry = 1'b1;
               state_in = palbl_pkg::ST_SLOT_RD;
            end else if (stat.last_index) begin
               ctrl.clr_index = 1'b1;
               state_in = palbl_pkg::ST_SCAN_RD;
            end else begin
               ctrl.inc_index = 1'b1;
               state_in = palbl_pkg::ST_LOOKUP_RD;
            end
         end
         palbl_pkg::ST_SCAN_RD: begin
            ctrl.rd_entry = 1'b1;
            state_in = palbl_pkg::ST_SCAN_CHK;
         end
         palbl_pkg::ST_SCAN_CHK: begin
            if (stat.slot_free || stat.expired) begin
               ctrl.alloc_entry = 1'b1;
               ctrl.div_start = 1'b1;
               state_in = palbl_pkg::ST_DIV;
            end else if (stat.last_index) begin
               ctrl.emit = 1'b1;
               ctrl.emit_full = 1'b1;
               state_in = palbl_pkg::ST_DONE;
            end else begin
               ctrl.inc_index = 1'b1;
               state_in = palbl_pkg::ST_SCAN_RD;
            end
         end
         palbl_pkg::ST_SLOT_RD: begin
            ctrl.div_start = 1'b1;
            state_in = palbl_pkg::ST_DIV;
         end
         palbl_pkg::ST_DIV: begin
            if (stat.div_done) begin
               state_in = palbl_pkg::ST_UPDATE;
            end else begin
               ctrl.div_step = 1'b1;
            end
         end
         palbl_pkg::ST_UPDATE: begin
            ctrl.write_slot = 1'b1;
            ctrl.emit = 1'b1;
            state_in = palbl_pkg::ST_DONE;
         end
         palbl_pkg::ST_DONE: begin
            state_in = palbl_pkg::ST_IDLE;
         end
         default: begin
            state_in = palbl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/palbl_dp.sv
// ----------------------------------------------------------------------------
// palbl_dp
// Bucket table, configuration registers, serial divider and result register.
// ----------------------------------------------------------------------------
module palbl_dp #(
   parameter int NUM_ENTRIES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [palbl_pkg::ADDR_W-1:0]      req_peer_address,
   input  logic [palbl_pkg::TIME_W-1:0]      req_now_ms,
   input  logic                              req_is_local,
   input  logic                              csr_wr,
   input  logic [palbl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [palbl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  palbl_pkg::ctrl_type               ctrl,
   output palbl_pkg::stat_type               stat,
   output logic                              rsp_valid,
   output logic                              rsp_limited,
   output logic                              rsp_no_room
);

   localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int WIN_W = palbl_pkg::BURST_W + palbl_pkg::PERIOD_W;
   localparam int TW    = palbl_pkg::TIME_W;
   localparam int DCNT_W = 6;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

   logic [palbl_pkg::BURST_W-1:0]  burst_ff;
   logic [palbl_pkg::PERIOD_W-1:0] period_ff;
   logic [WIN_W-1:0]               window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff  <= palbl_pkg::BURST_RESET;
         period_ff <= palbl_pkg::PERIOD_RESET;
      end else if (csr_wr) begin
         case (csr_index)
            palbl_pkg::CSR_BURST_LIMIT: burst_ff <= csr_wdata[palbl_pkg::BURST_W-1:0];
            palbl_pkg::CSR_PERIOD_MS:   period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [palbl_pkg::PERIOD_W-1:0] per;
   assign per = (period_ff == '0) ? palbl_pkg::PERIOD_W'(1) : period_ff;

   // expiry window, registered off the config path
   always_ff @(posedge clock) begin
      window_ff <= WIN_W'(burst_ff) * WIN_W'(per);
   end

   // request capture
   logic [TW-1:0] addr_ff, now_ff;
   logic          local_ff;
   logic [IDX_W-1:0] idx_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         addr_ff  <= req_peer_address;
         now_ff   <= req_now_ms;
         local_ff <= req_is_local;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.load_req || ctrl.clr_index) begin
         idx_ff <= '0;
      end else if (ctrl.inc_index) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   // table
   logic [NUM_ENTRIES-1:0] valid_ff;
   logic [TW-1:0] mem_addr [NUM_ENTRIES];
   logic [TW-1:0] mem_time [NUM_ENTRIES];
   logic [palbl_pkg::BURST_W-1:0] mem_cnt [NUM_ENTRIES];
   logic [TW-1:0] rd_addr_ff, rd_time_ff;
   logic [palbl_pkg::BURST_W-1:0] rd_cnt_ff;
   logic rd_valid_ff;

   logic [palbl_pkg::BURST_W-1:0] new_cnt;
   logic [TW-1:0] new_time;
   logic          pass;

   always_ff @(posedge clock) begin
      if (ctrl.rd_entry) begin
         rd_addr_ff <= mem_addr[idx_ff];
         rd_time_ff <= mem_time[idx_ff];
         rd_cnt_ff  <= mem_cnt[idx_ff];
      end
      if (ctrl.alloc_entry) begin
         mem_addr[idx_ff] <= addr_ff;
         mem_time[idx_ff] <= now_ff;
         mem_cnt[idx_ff]  <= '0;
         rd_time_ff <= now_ff;
         rd_cnt_ff  <= '0;
      end else if (ctrl.write_slot) begin
         mem_time[idx_ff] <= new_time;
         mem_cnt[idx_ff]  <= new_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctrl.alloc_entry) begin
         valid_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_entry) begin
         rd_valid_ff <= valid_ff[idx_ff];
      end
   end

   logic [TW-1:0] gap;
   assign gap = now_ff - rd_time_ff;

   assign stat.is_local   = local_ff;
   assign stat.hit        = rd_valid_ff && (rd_addr_ff == addr_ff);
   assign stat.slot_free  = !rd_valid_ff;
   assign stat.expired    = rd_valid_ff && (rd_time_ff != '0) &&
                            (gap[TW-1] || ({1'b0, gap} > (TW+1)'(window_ff)));
   assign stat.last_index = (idx_ff == LAST_IDX);

   // restoring divider: gap / per, one quotient bit per cycle
   logic [TW-1:0] quo_ff;
   logic [palbl_pkg::PERIOD_W:0] rem_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic [palbl_pkg::PERIOD_W:0] trial;

   assign trial = {rem_ff[palbl_pkg::PERIOD_W-1:0], quo_ff[TW-1]};

   always_ff @(posedge clock) begin
      if (ctrl.div_start) begin
         dcnt_ff <= '0;
         quo_ff  <= '0;
         rem_ff  <= '0;
      end else if (ctrl.div_step) begin
         dcnt_ff <= dcnt_ff + DCNT_W'(1);
         if (dcnt_ff == '0) begin
            // first step loads the dividend
            quo_ff <= gap;
         end else if (trial >= {1'b0, per}) begin
            rem_ff <= trial - {1'b0, per};
            quo_ff <= {quo_ff[TW-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[TW-2:0], 1'b0};
         end
      end
   end

   assign stat.div_done = (dcnt_ff == DCNT_W'(TW + 1));

   // drain and count update
   logic drop_all;
   logic [palbl_pkg::BURST_W-1:0] drained;
   assign drop_all = gap[TW-1] || (quo_ff > TW'(rd_cnt_ff));
   assign drained  = drop_all ? '0 : rd_cnt_ff - quo_ff[palbl_pkg::BURST_W-1:0];
   assign pass     = (drained < burst_ff);
   assign new_cnt  = pass ? drained + palbl_pkg::BURST_W'(1) : drained;
   assign new_time = drop_all ? now_ff : now_ff - TW'(rem_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= ctrl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_limited <= ctrl.emit_full ? 1'b1 : (ctrl.emit_local ? 1'b0 : !pass);
         rsp_no_room <= ctrl.emit_full;
      end
   end

endmodule

// File: rtl/palbl_checker.sv
// ----------------------------------------------------------------------------
// palbl_checker
// Port-level checks of the limiter's request/result sequencing.
// ----------------------------------------------------------------------------
module palbl_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_limited,
   input logic rsp_no_room
);

   // an accepted request makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request not taken");

   // no result without a request in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("stray request result");

   // table full implies limited
   a_noroom: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_room) |-> rsp_limited)
      else $error("no_room without limited");

   // results are single-cycle pulses
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("double result");

endmodule

bind per_address_leaky_bucket_limiter palbl_checker u_palbl_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_limited (rsp_limited),
   .rsp_no_room (rsp_no_room)
);
